/* sv/qet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_pkg
// Shared widths, register indexes and item codes of the quantized elapsed
// time unit.
// ----------------------------------------------------------------------------
package qet_pkg;

	localparam int COUNTER_W   = 64;
	localparam int FREQ_W      = 32;
	localparam int QMS_W       = 10;
	localparam int QCNT_W      = 7;
	localparam int ELAPSED_W   = 16;
	localparam int DEPTH_W     = QMS_W + QCNT_W;
	localparam int MS_PER_SEC  = 1000;
	// ticks * 1000 + freq/2 stays below 2^74
	localparam int NUM_W       = COUNTER_W + 10;
	localparam int STEP_W      = 7;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = FREQ_W;

	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_COUNT  = 2'd2;

	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [FREQ_W-1:0]  FREQ_RESET = 32'd10000000;
	localparam logic [QMS_W-1:0]   QMS_RESET  = 10'd20;
	localparam logic [QCNT_W-1:0]  QCNT_RESET = 7'd10;

endpackage

/* sv/qet_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qet_req_if / qet_rsp_if
// Valid/ready channels of the quantized elapsed time unit: counter readings
// in, quantized elapsed times out.
// ----------------------------------------------------------------------------
interface qet_req_if;
	import qet_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [COUNTER_W-1:0] counter_now;

	modport source (output valid, output kind, output counter_now, input ready);
	modport sink   (input valid, input kind, input counter_now, output ready);
endinterface

interface qet_rsp_if;
	import qet_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_ms;
	logic                 saturated;

	modport source (output valid, output elapsed_ms, output saturated, input ready);
	modport sink   (input valid, input elapsed_ms, input saturated, output ready);
endinterface

/* sv/quantized_elapsed_time_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_elapsed_time_unit
// Measures elapsed time between free-running counter readings and reports it
// in whole quanta of milliseconds, with a saturation depth.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one reading per transaction. kind start latches the reading as
//   the reference and answers 0. kind sample converts the ticks since the last
//   reading to ms (rounded half up), adds the carried remainder, and answers
//   the whole quanta, or the depth quant_ms*quant_count with saturated set.
//   rsp carries exactly one result per req transaction, in order.
//   Configuration must be written through cfg_we/cfg_index/cfg_wdata only while idle; the unit does not enforce this.
// Timing:
//   A start goes straight to the finish state; a sample prepares, converts,
//   sums and, unless it saturates, divides again before finishing. One shared
//   restoring divide step per cycle does 74 steps for the ms conversion and 17
//   more by quant_ms; the result register loads before req.ready returns.
//   req.ready is high only while no transaction is in flight.
//   A result waits in the output register while rsp.ready is low; a finished
//   item is held until the register frees, and req stays blocked meanwhile.
// Reset:
//   arst_n clears the reference reading and the remainder to zero and loads
//   the register defaults (10 MHz, 20 ms quanta, 10 quanta).
// ----------------------------------------------------------------------------
module quantized_elapsed_time_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qet_pkg::CFG_DATA_W-1:0] cfg_wdata,
	qet_req_if.sink                        req,
	qet_rsp_if.source                      rsp
);
	import qet_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_DIV1 = 6'b000100,
		S_SUM  = 6'b001000,
		S_DIV2 = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [FREQ_W-1:0]    freq_q;
	logic [QMS_W-1:0]     qms_q;
	logic [QCNT_W-1:0]    qcnt_q;
	logic [COUNTER_W-1:0] last_q;
	logic [QMS_W-1:0]     leftover_q;
	logic [STEP_W-1:0]    cnt_q;
	logic                 out_valid_q;

	logic [COUNTER_W-1:0] ticks_q;
	logic [NUM_W-1:0]     div_q;
	logic [FREQ_W-1:0]    rem_q;
	logic [FREQ_W-1:0]    divisor_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   sum_q;
	logic [ELAPSED_W-1:0] res_ms_q;
	logic                 res_sat_q;
	logic [ELAPSED_W-1:0] out_ms_q;
	logic                 out_sat_q;

	logic                 req_fire;
	logic                 out_free;
	logic [FREQ_W-1:0]    freq_eff;
	logic [QMS_W-1:0]     qms_eff;
	logic [FREQ_W:0]      trial;
	logic [FREQ_W:0]      diff;
	logic                 ge;
	logic [FREQ_W-1:0]    rem_next;
	logic [FREQ_W:0]      sum_wide;
	logic                 sat;

	assign req.ready   = (state_q == S_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.elapsed_ms = out_ms_q;
	assign rsp.saturated  = out_sat_q;

	assign freq_eff = (freq_q == '0) ? FREQ_W'(1) : freq_q;
	assign qms_eff  = (qms_q == '0) ? QMS_W'(1) : qms_q;

	// shared restoring divide step
	assign trial    = {rem_q, div_q[NUM_W-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign ge       = (trial >= {1'b0, divisor_q});
	assign rem_next = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];

	// quotient of the conversion sits in div_q after the first pass
	assign sum_wide = {1'b0, div_q[FREQ_W-1:0]} + (FREQ_W+1)'(leftover_q);
	assign sat      = (|div_q[NUM_W-1:FREQ_W]) ||
		(sum_wide > (FREQ_W+1)'(depth_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			freq_q      <= FREQ_RESET;
			qms_q       <= QMS_RESET;
			qcnt_q      <= QCNT_RESET;
			last_q      <= '0;
			leftover_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COUNTER_FREQ: freq_q <= cfg_wdata;
					CFG_QUANT_MS:     qms_q  <= cfg_wdata[QMS_W-1:0];
					CFG_QUANT_COUNT:  qcnt_q <= cfg_wdata[QCNT_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						last_q  <= req.counter_now;
						state_q <= (req.kind == KIND_SAMPLE) ? S_PREP : S_FIN;
					end
				end
				S_PREP: begin
					cnt_q   <= STEP_W'(NUM_W);
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					cnt_q <= cnt_q - STEP_W'(1);
					if (cnt_q == STEP_W'(1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (sat) begin
						leftover_q <= '0;
						state_q    <= S_FIN;
					end else begin
						cnt_q   <= STEP_W'(DEPTH_W);
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					cnt_q <= cnt_q - STEP_W'(1);
					if (cnt_q == STEP_W'(1)) begin
						leftover_q <= rem_next[QMS_W-1:0];
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ticks_q   <= req.counter_now - last_q;
				res_ms_q  <= '0;
				res_sat_q <= 1'b0;
				depth_q   <= DEPTH_W'(qms_eff) * DEPTH_W'(qcnt_q);
			end
			S_PREP: begin
				// ticks * 1000 as ticks * (1024 - 16 - 8)
				div_q     <= (NUM_W'(ticks_q) << 10) - (NUM_W'(ticks_q) << 4) -
					(NUM_W'(ticks_q) << 3) + NUM_W'(freq_eff >> 1);
				rem_q     <= '0;
				divisor_q <= freq_eff;
			end
			S_DIV1: begin
				div_q <= {div_q[NUM_W-2:0], ge};
				rem_q <= rem_next;
			end
			S_SUM: begin
				if (sat) begin
					res_ms_q  <= (depth_q > DEPTH_W'({ELAPSED_W{1'b1}})) ?
						{ELAPSED_W{1'b1}} : depth_q[ELAPSED_W-1:0];
					res_sat_q <= 1'b1;
				end else begin
					sum_q     <= sum_wide[DEPTH_W-1:0];
					div_q     <= {sum_wide[DEPTH_W-1:0], {(NUM_W-DEPTH_W){1'b0}}};
					rem_q     <= '0;
					divisor_q <= FREQ_W'(qms_eff);
				end
			end
			S_DIV2: begin
				div_q <= {div_q[NUM_W-2:0], ge};
				rem_q <= rem_next;
			end
			S_FIN: ;
			default: ;
		endcase
		if (state_q == S_DIV2 && cnt_q == STEP_W'(1)) begin
			// sum - remainder: whole quanta in ms, from the last step's remainder
			res_ms_q  <= ((sum_q - rem_next[DEPTH_W-1:0]) > DEPTH_W'({ELAPSED_W{1'b1}})) ?
				{ELAPSED_W{1'b1}} : ELAPSED_W'(sum_q - rem_next[DEPTH_W-1:0]);
			res_sat_q <= 1'b0;
		end
		if (state_q == S_FIN && out_free) begin
			out_ms_q  <= res_ms_q;
			out_sat_q <= res_sat_q;
		end
	end

	// remainder of the shared divider never reaches the divisor
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (rem_q < divisor_q))
		else $error("divider remainder not below divisor");

	a_sample_enters_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.kind == KIND_SAMPLE) |=> (state_q == S_PREP))
		else $error("sample transaction did not start conversion");

	a_steps_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (cnt_q != '0))
		else $error("divide state with no steps left");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result loaded outside finish state");

	a_sat_clears_leftover: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && res_sat_q) |-> (leftover_q == '0))
		else $error("saturated result kept a remainder");

endmodule
